// ----- rtl/scap_pkg.sv -----
`default_nettype none

package scap_pkg;

	// Longest answer that the byte buffer holds.
	localparam int MaxLen = 33;

	localparam logic [15:0] TimeoutReset = 16'd34;
	localparam logic [7:0]  TsValue      = 8'h3f;
	localparam logic [2:0]  TsTriesMax   = 3'd5;

	// Input commands (carried in s_tuser).
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_OK      = 3'd2;
	localparam logic [2:0] ST_NO_TS   = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_BAD_SUM = 3'd5;

	typedef struct packed {
		logic [2:0] status;
		logic       byte_valid;
		logic [7:0] atr_byte;
		logic [5:0] byte_index;
		logic [5:0] atr_length;
	} scap_result_t;

	// Inverse convention: reverse the bit order, then invert.
	function automatic logic [7:0] convert_byte(input logic [7:0] raw);
		logic [7:0] c;
		for (int j = 0; j < 8; j++) begin
			c[7 - j] = raw[j];
		end
		return ~c;
	endfunction

	function automatic logic [1:0] lowest_slot(input logic [3:0] m);
		logic [1:0] r;
		if (m[0]) begin
			r = 2'd0;
		end else if (m[1]) begin
			r = 2'd1;
		end else if (m[2]) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/scap_core.sv -----
`default_nettype none

module scap_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [1:0]            command,
	input  wire logic [7:0]            line_byte,
	input  wire logic [15:0]           timeout_ticks,
	output scap_pkg::scap_result_t     res
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TS    = 3'd1;
	localparam logic [2:0] PH_T0    = 3'd2;
	localparam logic [2:0] PH_IFACE = 3'd3;
	localparam logic [2:0] PH_HIST  = 3'd4;
	localparam logic [2:0] PH_TCK   = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  ts_tries_q, ts_tries_d;
	logic [5:0]  position_q, position_d;
	logic [3:0]  pending_q, pending_d;
	logic [1:0]  nibble_q, nibble_d;
	logic [3:0]  hist_total_q, hist_total_d;
	logic [3:0]  hist_left_q, hist_left_d;
	logic        check_q, check_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] wait_q, wait_d;

	logic [7:0]  conv;
	logic [2:0]  st;
	logic        do_group, do_hist, do_after;
	logic [6:0]  bound_sum;

	assign conv = scap_pkg::convert_byte(line_byte);

	always_comb begin
		phase_d      = phase_q;
		ts_tries_d   = ts_tries_q;
		position_d   = position_q;
		pending_d    = pending_q;
		nibble_d     = nibble_q;
		hist_total_d = hist_total_q;
		hist_left_d  = hist_left_q;
		check_d      = check_q;
		xor_d        = xor_q;
		wait_d       = wait_q;
		st           = scap_pkg::ST_BUSY;
		do_group     = 1'b0;
		do_hist      = 1'b0;
		do_after     = 1'b0;
		res          = '0;

		if (command == scap_pkg::CMD_START) begin
			phase_d      = PH_TS;
			ts_tries_d   = '0;
			position_d   = '0;
			pending_d    = '0;
			nibble_d     = '0;
			hist_total_d = '0;
			hist_left_d  = '0;
			check_d      = 1'b0;
			xor_d        = '0;
			wait_d       = '0;
		end else if (phase_q == PH_IDLE || phase_q > PH_TCK) begin
			phase_d = PH_IDLE;
			st      = scap_pkg::ST_IDLE;
		end else if (command == scap_pkg::CMD_TICK) begin
			if (wait_q != 16'hffff) begin
				wait_d = wait_q + 16'd1;
			end
			if (wait_d >= timeout_ticks) begin
				phase_d = PH_IDLE;
				st      = scap_pkg::ST_TIMEOUT;
			end
		end else if (command == scap_pkg::CMD_BYTE) begin
			res.byte_valid = 1'b1;
			res.atr_byte   = conv;
			if (phase_q == PH_TS) begin
				wait_d = '0;
				if (conv == scap_pkg::TsValue) begin
					position_d = 6'd1;
					xor_d      = '0;
					phase_d    = PH_T0;
				end else begin
					ts_tries_d = ts_tries_q + 3'd1;
					if (ts_tries_d >= scap_pkg::TsTriesMax) begin
						phase_d = PH_IDLE;
						st      = scap_pkg::ST_NO_TS;
					end
				end
			end else begin
				res.byte_index = position_q;
				position_d     = position_q + 6'd1;
				xor_d          = xor_q ^ conv;
				if (phase_q == PH_T0) begin
					hist_total_d = conv[3:0];
					pending_d    = conv[7:4];
					check_d      = 1'b0;
					do_group     = 1'b1;
				end else if (phase_q == PH_IFACE) begin
					if (nibble_q == 2'd3) begin
						// TD byte: a protocol other than T=0 needs a TCK.
						if (conv[3:0] != 4'd0) begin
							check_d = 1'b1;
						end
						pending_d = conv[7:4];
						do_group  = 1'b1;
					end else begin
						pending_d = pending_q & ~(4'd1 << nibble_q);
						if (pending_d == 4'd0) begin
							do_hist = 1'b1;
						end else begin
							nibble_d = scap_pkg::lowest_slot(pending_d);
							wait_d   = '0;
						end
					end
				end else if (phase_q == PH_HIST) begin
					hist_left_d = hist_left_q - 4'd1;
					if (hist_left_d == 4'd0) begin
						do_after = 1'b1;
					end
				end else begin
					phase_d = PH_IDLE;
					st = (xor_d == 8'd0) ? scap_pkg::ST_OK : scap_pkg::ST_BAD_SUM;
				end
			end
		end

		// Room for another interface group: position + 5 + K below the buffer size.
		bound_sum = {1'b0, position_d} + {3'b000, hist_total_d} + 7'd5;

		// Start the next interface group, else move on to the historical bytes.
		if (do_group) begin
			if (pending_d != 4'd0 && bound_sum < 7'(scap_pkg::MaxLen)) begin
				phase_d  = PH_IFACE;
				nibble_d = scap_pkg::lowest_slot(pending_d);
				wait_d   = '0;
			end else begin
				do_hist = 1'b1;
			end
		end
		if (do_hist) begin
			pending_d = '0;
			wait_d    = '0;
			if (hist_total_d != 4'd0) begin
				hist_left_d = hist_total_d;
				phase_d     = PH_HIST;
			end else begin
				do_after = 1'b1;
			end
		end
		if (do_after) begin
			wait_d = '0;
			if (check_d) begin
				phase_d = PH_TCK;
			end else begin
				phase_d = PH_IDLE;
				st      = scap_pkg::ST_OK;
			end
		end

		res.status     = st;
		res.atr_length = (st == scap_pkg::ST_OK) ? position_d : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			ts_tries_q   <= '0;
			position_q   <= '0;
			pending_q    <= '0;
			nibble_q     <= '0;
			hist_total_q <= '0;
			hist_left_q  <= '0;
			check_q      <= 1'b0;
			xor_q        <= '0;
			wait_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			ts_tries_q   <= ts_tries_d;
			position_q   <= position_d;
			pending_q    <= pending_d;
			nibble_q     <= nibble_d;
			hist_total_q <= hist_total_d;
			hist_left_q  <= hist_left_d;
			check_q      <= check_d;
			xor_q        <= xor_d;
			wait_q       <= wait_d;
		end
	end

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.status == scap_pkg::ST_OK || res.status == scap_pkg::ST_NO_TS ||
		         res.status == scap_pkg::ST_TIMEOUT || res.status == scap_pkg::ST_BAD_SUM)
		|=> phase_q == PH_IDLE)
		else $error("parser did not return to idle after a final status");

	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		step && command == scap_pkg::CMD_START
		|=> phase_q == PH_TS && position_q == 6'd0 && ts_tries_q == 3'd0)
		else $error("start did not restart the TS search");

	a_byte_needs_parse: assert property (@(posedge clk) disable iff (!arst_n)
		res.byte_valid |-> phase_q != PH_IDLE && phase_q <= PH_TCK)
		else $error("byte stored while no parse was running");

	a_length_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.atr_length != 6'd0 |-> res.status == scap_pkg::ST_OK)
		else $error("answer length reported without a good status");

endmodule

`default_nettype wire

// ----- rtl/smart_card_atr_parser_unit.sv -----
// Answer-to-reset parser for inverse-convention smart card lines.
// Input stream (s_*): one transfer per event. s_tuser holds the command
// (start parse, line byte arrived, time tick) and s_tdata holds the raw line
// byte, which is only looked at for a line byte.
// Output stream (m_*): exactly one result transfer for each input transfer,
// in order. m_tuser holds the status and the byte-stored flag, m_tdata the
// converted byte, its position in the answer and the final answer length.
// Configuration (cfg_*): writes the per-wait tick limit; always ready. It
// should only be written while no result is outstanding.
// The result passes through the input register and then the result register
// before it is shown. Throughput is one item per cycle while the receiver
// keeps m_tready high, set by the state update in the parser core, which
// takes one input transfer each time the input register moves on.
// Reset clears all parse state to idle, empties both registers and loads the
// tick limit with its default of 34. When the receiver holds m_tready low the
// result register holds its transfer, the input register fills behind it and
// s_tready drops until the result is taken.
`default_nettype none

module smart_card_atr_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [7:0] atr_byte, [13:8] byte_index,
	                                    // [19:14] atr_length, [23:20] zero
	output      logic [3:0]  m_tuser,   // [2:0] status, [3] byte_valid
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data   // timeout_ticks
);

	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic [15:0] timeout_q;
	logic        out_valid_q;
	scap_pkg::scap_result_t res;
	scap_pkg::scap_result_t res_s2;

	// The input register moves on whenever the result register is free or is
	// being emptied in this cycle, so the pipeline streams at full rate.
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= scap_pkg::TimeoutReset;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// The payload register needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			byte_s1    <= s_tdata;
		end
	end

	scap_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.command       (command_s1),
		.line_byte     (byte_s1),
		.timeout_ticks (timeout_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_s2.atr_length, res_s2.byte_index, res_s2.atr_byte};
	assign m_tuser  = {res_s2.byte_valid, res_s2.status};

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

// Checks the answer-to-reset parser end to end through its streams.
// A directed table runs first, then random answers with noise. Every result
// transfer is compared with a prediction made when its input transfer is taken.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// The slowest legal run, with long receiver stalls and sender gaps, fits well
	// inside this.
	localparam int CycleLimit = 500000;
	localparam int HoldCycles = 300;
	localparam int ItemsPerPhase = 175;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TS, PH_T0, PH_IFACE, PH_HIST, PH_TCK
	} parse_phase_t;

	// One row of the directed part. When set_limit is high, the tick limit is
	// written before the row's transfer. When typed is high, the result columns
	// are the expected result. Otherwise the predictor supplies it.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  atr;
		logic        set_limit;
		logic [15:0] limit;
		logic        typed;
		logic [2:0]  status;
		logic        bv;
		logic [7:0]  ab;
		logic [5:0]  bi;
		logic [5:0]  len;
	} plan_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic [1:0]  s_tuser   = scap_pkg::CMD_NONE;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = 16'd0;

	smart_card_atr_parser_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser state as the predictor keeps it. It is updated in the same order
	// in which the input transfers are taken.
	parse_phase_t ph         = PH_IDLE;
	logic [2:0]   ts_misses  = '0;
	logic [5:0]   pos        = '0;
	logic [3:0]   y_left     = '0;
	logic [1:0]   slot       = '0;
	logic [3:0]   k_total    = '0;
	logic [3:0]   k_left     = '0;
	logic         tck_due    = 1'b0;
	logic [7:0]   xsum       = '0;
	logic [15:0]  wait_ticks = '0;
	logic [15:0]  tick_limit = scap_pkg::TimeoutReset;

	scap_pkg::scap_result_t answer_reports[$];
	int items_sent = 0;
	int mismatches = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int cycle_count = 0;

	// The inverse convention reverses the bit order and inverts the result.
	function automatic logic [7:0] line_to_atr(input logic [7:0] raw);
		logic [7:0] flipped;
		flipped = {<<{raw}};
		return ~flipped;
	endfunction

	// This is the inverse of the conversion above. It gives the line byte that
	// carries a wanted answer byte.
	function automatic logic [7:0] atr_to_line(input logic [7:0] c);
		logic [7:0] inv;
		logic [7:0] flipped;
		inv = ~c;
		flipped = {<<{inv}};
		return flipped;
	endfunction

	// The interface bytes come in the order TA, TB, TC, TD. So the next slot is
	// the lowest bit still set.
	function automatic logic [1:0] first_slot(input logic [3:0] m);
		first_slot = 2'd3;
		for (int i = 3; i >= 0; i--) begin
			if (m[i]) begin
				first_slot = 2'(i);
			end
		end
	endfunction

	// The historical bytes are done. TCK follows only if some TD named a
	// protocol other than T=0.
	function automatic logic [2:0] finish_hist();
		wait_ticks = '0;
		if (tck_due) begin
			ph = PH_TCK;
			return scap_pkg::ST_BUSY;
		end
		ph = PH_IDLE;
		return scap_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] start_hist();
		y_left = '0;
		wait_ticks = '0;
		if (k_total != 4'd0) begin
			k_left = k_total;
			ph = PH_HIST;
			return scap_pkg::ST_BUSY;
		end
		return finish_hist();
	endfunction

	// A new interface group opens only while the answer buffer still has room
	// for it and for the historical bytes. Otherwise the remaining Y bits are dropped.
	function automatic logic [2:0] open_group();
		if (y_left != 4'd0 && int'(pos) < scap_pkg::MaxLen - 5 - int'(k_total)) begin
			ph = PH_IFACE;
			slot = first_slot(y_left);
			wait_ticks = '0;
			return scap_pkg::ST_BUSY;
		end
		return start_hist();
	endfunction

	// This works out the result of one input transfer and advances the state.
	task automatic atr_step(input logic [1:0] cmd, input logic [7:0] raw,
		output scap_pkg::scap_result_t r);
		logic [7:0] c;
		c = line_to_atr(raw);
		r = '0;
		if (cmd == scap_pkg::CMD_START) begin
			ph = PH_TS;
			ts_misses = '0;
			pos = '0;
			y_left = '0;
			slot = '0;
			k_total = '0;
			k_left = '0;
			tck_due = 1'b0;
			xsum = '0;
			wait_ticks = '0;
			r.status = scap_pkg::ST_BUSY;
		end else if (ph == PH_IDLE) begin
			r.status = scap_pkg::ST_IDLE;
		end else if (cmd == scap_pkg::CMD_TICK) begin
			if (wait_ticks != 16'hffff) begin
				wait_ticks = wait_ticks + 16'd1;
			end
			if (wait_ticks >= tick_limit) begin
				ph = PH_IDLE;
				r.status = scap_pkg::ST_TIMEOUT;
			end else begin
				r.status = scap_pkg::ST_BUSY;
			end
		end else if (cmd == scap_pkg::CMD_NONE) begin
			r.status = scap_pkg::ST_BUSY;
		end else begin
			r.byte_valid = 1'b1;
			r.atr_byte = c;
			if (ph == PH_TS) begin
				// Each TS candidate is echoed at index 0.
				wait_ticks = '0;
				if (c == scap_pkg::TsValue) begin
					pos = 6'd1;
					xsum = '0;
					ph = PH_T0;
					r.status = scap_pkg::ST_BUSY;
				end else begin
					ts_misses = ts_misses + 3'd1;
					if (ts_misses >= scap_pkg::TsTriesMax) begin
						ph = PH_IDLE;
						r.status = scap_pkg::ST_NO_TS;
					end else begin
						r.status = scap_pkg::ST_BUSY;
					end
				end
			end else begin
				r.byte_index = pos;
				pos = pos + 6'd1;
				xsum = xsum ^ c;
				case (ph)
					PH_T0: begin
						k_total = c[3:0];
						y_left = c[7:4];
						tck_due = 1'b0;
						r.status = open_group();
					end
					PH_IFACE: begin
						if (slot == 2'd3) begin
							if (c[3:0] != 4'd0) begin
								tck_due = 1'b1;
							end
							y_left = c[7:4];
							r.status = open_group();
						end else begin
							y_left[slot] = 1'b0;
							if (y_left == 4'd0) begin
								r.status = start_hist();
							end else begin
								slot = first_slot(y_left);
								wait_ticks = '0;
								r.status = scap_pkg::ST_BUSY;
							end
						end
					end
					PH_HIST: begin
						k_left = k_left - 4'd1;
						r.status = (k_left == 4'd0) ? finish_hist() : scap_pkg::ST_BUSY;
					end
					default: begin
						// This is TCK. The XOR over T0 through TCK must be zero.
						ph = PH_IDLE;
						r.status = (xsum == 8'd0) ? scap_pkg::ST_OK : scap_pkg::ST_BAD_SUM;
					end
				endcase
			end
		end
		if (r.status == scap_pkg::ST_OK) begin
			r.atr_length = pos;
		end
	endtask

	// This offers one item after a random gap and waits for its transfer. The
	// predicted result is queued at that edge. Valid stays high after the
	// transfer, so back-to-back items never lower and raise it in one step.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] raw);
		scap_pkg::scap_result_t r;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		if (cmd == scap_pkg::CMD_START || ph != PH_IDLE) begin
			items_sent++;
		end
		atr_step(cmd, raw, r);
		answer_reports.push_back(r);
	endtask

	// The sender stays silent until every queued result has been received.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answer_reports.size() != 0);
	endtask

	// The tick limit is written only while the parser has nothing in flight.
	// The block holds at most two items; drain() empties it before the write.
	task automatic write_limit(input logic [15:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tick_limit = v;
	endtask

	// Random commands and bytes, mostly ignored while the parser is idle.
	task automatic noise_burst();
		repeat ($urandom_range(6, 1)) begin
			send_item(2'($urandom_range(3)), 8'($urandom));
		end
	endtask

	// This sends one answer. Each byte is chosen from the predicted phase, so
	// most answers are well formed and get deep into the parse. Ticks, stray
	// commands, missed TS bytes, bad checksums and cut-off answers are mixed in.
	task automatic random_answer();
		int miss_pct;
		int n;
		logic [7:0] c;
		miss_pct = ($urandom_range(99) < 8) ? 100 : 20;
		send_item(scap_pkg::CMD_START, 8'($urandom));
		n = 0;
		while (ph != PH_IDLE && n < 60) begin
			n++;
			if ($urandom_range(99) < 3) begin
				return;
			end
			if ($urandom_range(99) < 2 && tick_limit <= 16'd100) begin
				// Let the current wait run out.
				while (ph != PH_IDLE) begin
					send_item(scap_pkg::CMD_TICK, 8'($urandom));
				end
				return;
			end
			if ($urandom_range(99) < 12) begin
				if ($urandom_range(99) < 15) begin
					send_item(scap_pkg::CMD_NONE, 8'($urandom));
				end else if (wait_ticks + 1 < tick_limit || $urandom_range(99) < 10) begin
					send_item(scap_pkg::CMD_TICK, 8'($urandom));
				end
				continue;
			end
			case (ph)
				PH_TS: begin
					c = ($urandom_range(99) < miss_pct) ? 8'($urandom) : scap_pkg::TsValue;
				end
				PH_T0: begin
					c = {4'($urandom),
						($urandom_range(1) != 0) ? 4'($urandom_range(3)) : 4'($urandom)};
				end
				PH_IFACE: begin
					if (slot == 2'd3) begin
						// The TD byte carries on the chain more often than not.
						c = {($urandom_range(99) < 65) ? (4'b1000 | 4'($urandom)) : 4'($urandom),
							($urandom_range(1) != 0) ? 4'd0 : 4'($urandom)};
					end else begin
						c = 8'($urandom);
					end
				end
				PH_TCK: begin
					c = ($urandom_range(99) < 80) ? xsum : 8'($urandom);
				end
				default: begin
					c = 8'($urandom);
				end
			endcase
			send_item(scap_pkg::CMD_BYTE, atr_to_line(c));
		end
	endtask

	// The directed part. The first answer is T0=81, TD1=11, TA2=96, one
	// historical byte and TCK. Then come five missed TS bytes, the shortest
	// answer, a bad checksum, a restart followed by a timeout with limit 1, and
	// an immediate timeout with limit 0.
	plan_row_t plan_rows [26] = '{
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b0, 16'd0, 1'b1, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_TICK,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_NONE,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_START, 8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'hff, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b1, 8'hff, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b1, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b1, 8'h3f, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h81, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h11, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h96, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h55, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h53, 1'b0, 16'd0, 1'b1, scap_pkg::ST_OK,
			1'b1, 8'h53, 6'd5, 6'd6},
		'{scap_pkg::CMD_START, 8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_NO_TS,
			1'b1, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_START, 8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_OK,
			1'b1, 8'h00, 6'd1, 6'd2},
		'{scap_pkg::CMD_START, 8'h00, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h80, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h01, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BAD_SUM,
			1'b1, 8'h00, 6'd3, 6'd0}
	};

	plan_row_t limit_rows [7] = '{
		'{scap_pkg::CMD_START, 8'h00, 1'b1, 16'd1, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b0, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_START, 8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_BUSY,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_TICK,  8'h00, 1'b0, 16'd0, 1'b1, scap_pkg::ST_TIMEOUT,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_START, 8'h00, 1'b1, 16'd0, 1'b0, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_TICK,  8'hff, 1'b0, 16'd0, 1'b1, scap_pkg::ST_TIMEOUT,
			1'b0, 8'h00, 6'd0, 6'd0},
		'{scap_pkg::CMD_BYTE,  8'h3f, 1'b1, 16'hffff, 1'b1, scap_pkg::ST_IDLE,
			1'b0, 8'h00, 6'd0, 6'd0}
	};

	// Settings for the random phases. Each phase has its own tick limit. The
	// idling pattern repeats every four phases: none, sender idle, receiver
	// stalling, then both.
	logic [15:0] phase_limits [8] = '{16'd20, 16'd7, 16'd34, 16'd1,
		16'hffff, 16'd3, 16'd100, 16'd12};
	int phase_gaps [4] = '{0, 74, 0, 32};
	int phase_stalls [4] = '{0, 0, 74, 32};

	// The receiver takes results at random. When a hold is requested, it refuses
	// them for a long stretch, so the input side must stall.
	int hold_left = 0;
	int holds_served = 0;

	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= hold_requests;
			hold_left <= HoldCycles;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Each result transfer is compared field by field with the oldest prediction.
	scap_pkg::scap_result_t got;
	scap_pkg::scap_result_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[2:0], m_tuser[3], m_tdata[7:0], m_tdata[13:8], m_tdata[19:14]};
			if (answer_reports.size() == 0) begin
				if (mismatches < 40) begin
					$display("%0t: result with none expected, got status %0d valid %0d %s",
						$time, got.status, got.byte_valid,
						$sformatf("byte %02h index %0d length %0d",
							got.atr_byte, got.byte_index, got.atr_length));
				end
				mismatches++;
			end else begin
				want = answer_reports.pop_front();
				if (got !== want || m_tdata[23:20] !== 4'd0) begin
					if (mismatches < 40) begin
						$display("%0t: expected status %0d valid %0d byte %02h index %0d length %0d pad 0",
							$time, want.status, want.byte_valid, want.atr_byte, want.byte_index,
							want.atr_length);
						$display("%0t: actual   status %0d valid %0d byte %02h index %0d length %0d pad %0h",
							$time, got.status, got.byte_valid, got.atr_byte, got.byte_index,
							got.atr_length, m_tdata[23:20]);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// In the directed rows a typed result replaces the prediction that
		// send_item has just queued.
		foreach (plan_rows[i]) begin
			send_item(plan_rows[i].cmd, atr_to_line(plan_rows[i].atr));
			if (plan_rows[i].typed) begin
				answer_reports[$] = {plan_rows[i].status, plan_rows[i].bv,
					plan_rows[i].ab, plan_rows[i].bi, plan_rows[i].len};
			end
		end
		foreach (limit_rows[i]) begin
			if (limit_rows[i].set_limit) begin
				write_limit(limit_rows[i].limit);
			end
			send_item(limit_rows[i].cmd, atr_to_line(limit_rows[i].atr));
			if (limit_rows[i].typed) begin
				answer_reports[$] = {limit_rows[i].status, limit_rows[i].bv,
					limit_rows[i].ab, limit_rows[i].bi, limit_rows[i].len};
			end
		end

		for (int p = 0; p < 8; p++) begin
			write_limit(phase_limits[p]);
			gap_pct = phase_gaps[p % 4];
			stall_pct = phase_stalls[p % 4];
			if (p == 0) begin
				// The sender keeps offering items while the receiver holds off.
				hold_requests++;
			end
			items_sent = 0;
			while (items_sent < ItemsPerPhase) begin
				if ($urandom_range(99) < 10) begin
					noise_burst();
				end else begin
					random_answer();
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- smart_card_atr_parser_unit.f -----
rtl/scap_pkg.sv
rtl/scap_core.sv
rtl/smart_card_atr_parser_unit.sv
tb/sv/testbench.sv
